FILE: design/ppm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the polygon perimeter block
// Coordinate width, root unit sizing, edge queue item and back-end states.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int COORD_BITS  = 16;
    localparam int SUM_W       = 48;
    localparam int SQ_W        = 2 * COORD_BITS + 1;
    localparam int RAD_W       = SQ_W + 8 + ((SQ_W + 8) % 2);
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 1;
    localparam int ITER_W      = $clog2(ROOT_W);
    localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

    // power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic                  close;
    } edge_cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_LOAD,
        BK_ROOT,
        BK_ACCUM
    } back_state_t;

endpackage

FILE: design/polygon_perimeter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_perimeter: streaming polygon perimeter
// Input channel s_axis: one vertex per item, x and y signed with 4 fractional
// bits, tlast on the closing vertex. Output channel m_axis: one item per
// polygon, the perimeter in 1/256 units and a saturation flag.
// Each vertex after the first becomes one edge; the closing vertex adds the
// edge back to the first vertex. Edges wait in a 4-entry queue and are worked
// one at a time by a shared root unit, each edge in turn through queue pop, square,
// load, 21 root iterations at two radicand bits each, and accumulate.
// Vertices are taken while the queue has room; the result leaves once both
// edges of the closing vertex are worked, later if edges are still queued
// ahead of it.
// Reset clears the vertex state, queue, running sum and the output valid flag.
// A stalled receiver holds the result in the output register; the root unit
// keeps working and only waits when the next result is ready to be stored.
// ----------------------------------------------------------------------------
module polygon_perimeter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ppm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // x_coord, y_coord
    input  logic                            s_axis_tlast,   // last_vertex
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ppm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // perimeter
    output logic [0:0]                      m_axis_tuser    // saturated
);
    import ppm_pkg::*;

    logic          push;
    logic          pop;
    edge_cmd_t     push_cmd;
    edge_cmd_t     pop_cmd;
    queue_status_t q_status;

    ppm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_status      (q_status)
    );

    ppm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    ppm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop           (pop),
        .pop_cmd       (pop_cmd),
        .q_status      (q_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("edge queue overflow");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("edge queue underflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("edge queue count out of range");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !q_status.full)
        else $error("vertex taken with no queue room");
`endif

endmodule

FILE: design/ppm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_front: vertex intake
// Keeps first and previous vertex, turns each later vertex into edge queue
// commands (|dx|, |dy|, close). A closing vertex gives two, a lone vertex one.
// ----------------------------------------------------------------------------
module ppm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ppm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // x_coord, y_coord
    input  logic                             s_axis_tlast,   // last_vertex
    output logic                             push,
    output ppm_pkg::edge_cmd_t               push_cmd,
    input  ppm_pkg::queue_status_t           q_status
);
    import ppm_pkg::*;

    logic [COORD_BITS-1:0] first_x_reg, first_x_next;
    logic [COORD_BITS-1:0] first_y_reg, first_y_next;
    logic [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic                  have_first_reg, have_first_next;
    logic                  pend_reg, pend_next;
    edge_cmd_t             pend_cmd_reg, pend_cmd_next;

    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  accept;
    edge_cmd_t             edge_cmd;
    edge_cmd_t             close_cmd;
    edge_cmd_t             single_cmd;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        return m[COORD_BITS-1:0];
    endfunction

    assign x = s_axis_tdata[COORD_BITS-1:0];
    assign y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    assign s_axis_tready = !pend_reg && !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        edge_cmd.dx      = abs_diff(prev_x_reg, x);
        edge_cmd.dy      = abs_diff(prev_y_reg, y);
        edge_cmd.close   = 1'b0;
        close_cmd.dx     = abs_diff(x, first_x_reg);
        close_cmd.dy     = abs_diff(y, first_y_reg);
        close_cmd.close  = 1'b1;
        single_cmd.dx    = '0;
        single_cmd.dy    = '0;
        single_cmd.close = 1'b1;
    end

    always_comb
    begin
        push            = 1'b0;
        push_cmd        = edge_cmd;
        pend_next       = pend_reg;
        pend_cmd_next   = pend_cmd_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        have_first_next = have_first_reg;

        if (pend_reg)
        begin
            push     = !q_status.full;
            push_cmd = pend_cmd_reg;
            if (!q_status.full)
            begin
                pend_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (have_first_reg)
            begin
                push     = 1'b1;
                push_cmd = edge_cmd;
                if (s_axis_tlast)
                begin
                    pend_next     = 1'b1;
                    pend_cmd_next = close_cmd;
                end
            end
            else
            begin
                first_x_next = x;
                first_y_next = y;
                if (s_axis_tlast)
                begin
                    push     = 1'b1;
                    push_cmd = single_cmd;
                end
            end
            prev_x_next     = x;
            prev_y_next     = y;
            have_first_next = !s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            have_first_reg <= have_first_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_x_reg  <= first_x_next;
        first_y_reg  <= first_y_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

FILE: design/ppm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_queue: edge command queue
// Small first-in first-out buffer between intake and the root unit.
// ----------------------------------------------------------------------------
module ppm_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ppm_pkg::edge_cmd_t     push_cmd,
    input  logic                   pop,
    output ppm_pkg::edge_cmd_t     pop_cmd,
    output ppm_pkg::queue_status_t q_status
);
    import ppm_pkg::*;

    edge_cmd_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    assign pop_cmd        = mem[rd_ptr_reg];
    assign q_status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (cnt_reg == '0);
    assign q_status.count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/ppm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_back: edge length and perimeter accumulation
// Squares |dx| and |dy|, takes floor(sqrt(sum << 8)) two radicand bits per
// cycle, adds the length with saturation and emits on a closing edge.
// ----------------------------------------------------------------------------
module ppm_back (
    input  logic                            clk,
    input  logic                            rst_n,
    output logic                            pop,
    input  ppm_pkg::edge_cmd_t              pop_cmd,
    input  ppm_pkg::queue_status_t          q_status,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ppm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // perimeter
    output logic [0:0]                      m_axis_tuser    // saturated
);
    import ppm_pkg::*;

    back_state_t                 state_reg, state_next;
    edge_cmd_t                   cmd_reg, cmd_next;
    logic [2*COORD_BITS-1:0]     dxsq_reg, dxsq_next;
    logic [2*COORD_BITS-1:0]     dysq_reg, dysq_next;
    logic [RAD_W-1:0]            rad_reg, rad_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [ROOT_W-1:0]           root_reg, root_next;
    logic [ITER_W-1:0]           iter_reg, iter_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic                        clip_reg, clip_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]            out_sum_reg, out_sum_next;
    logic                        out_sat_reg, out_sat_next;

    logic [REM_W+1:0]            rem_sh;
    logic [REM_W+1:0]            trial;
    logic                        ge;
    logic [REM_W+1:0]            rem_new;
    logic [SUM_W:0]              sum_wide;
    logic [SUM_W-1:0]            sum_sat;
    logic                        clip_new;

    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        ge       = (rem_sh >= trial);
        rem_new  = ge ? rem_sh - trial : rem_sh;
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(root_reg);
        sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        clip_new = clip_reg | sum_wide[SUM_W];
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        dxsq_next      = dxsq_reg;
        dysq_next      = dysq_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        iter_next      = iter_reg;
        sum_next       = sum_reg;
        clip_next      = clip_reg;
        out_sum_next   = out_sum_reg;
        out_sat_next   = out_sat_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        pop            = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = pop_cmd;
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE:
            begin
                dxsq_next  = cmd_reg.dx * cmd_reg.dx;
                dysq_next  = cmd_reg.dy * cmd_reg.dy;
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                rad_next   = RAD_W'({({1'b0, dxsq_reg} + {1'b0, dysq_reg}), 8'b0});
                rem_next   = '0;
                root_next  = '0;
                iter_next  = ITER_W'(ROOT_W - 1);
                state_next = BK_ROOT;
            end
            BK_ROOT:
            begin
                rem_next  = rem_new[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], ge};
                rad_next  = rad_reg << 2;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = BK_ACCUM;
                end
            end
            BK_ACCUM:
            begin
                if (!cmd_reg.close)
                begin
                    sum_next   = sum_sat;
                    clip_next  = clip_new;
                    state_next = BK_IDLE;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    out_sum_next   = sum_sat;
                    out_sat_next   = clip_new;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    clip_next      = 1'b0;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_TDATA_W'(out_sum_reg);
    assign m_axis_tuser[0] = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        dxsq_reg    <= dxsq_next;
        dysq_reg    <= dysq_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        out_sum_reg <= out_sum_next;
        out_sat_reg <= out_sat_next;
    end

endmodule
